FILE: rtl/hdtu_pkg.sv
package hdtu_pkg;

    localparam int unsigned RX_CAPACITY = 128;

    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_RX   = 2'd1;
    localparam logic [1:0] MODE_TX   = 2'd2;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_SEND  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [3:0] CNT_DATA_END = 4'd9;
    localparam logic [3:0] CNT_TX_LOAD  = 4'd10;
    localparam logic [7:0] SHIFT_MARK   = 8'hFF;

    typedef struct packed {
        logic [1:0] opcode;
        logic       rx_level;
        logic [7:0] data_byte;
    } req_item_t;

    typedef struct packed {
        logic       tx_level;
        logic       tx_done;
        logic       send_refused;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic [6:0] rx_index;
        logic       rx_stopped;
    } rsp_item_t;

endpackage

FILE: rtl/hdtu_ifs.sv
interface hdtu_req_if;
    import hdtu_pkg::*;
    logic      valid;
    logic      ready;
    req_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface hdtu_rsp_if;
    import hdtu_pkg::*;
    logic      valid;
    logic      ready;
    rsp_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface hdtu_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] link_mode;
    modport source (output valid, output link_mode, input ready);
    modport sink (input valid, input link_mode, output ready);
endinterface

FILE: rtl/half_duplex_tick_uart.sv
// Half-duplex 8N1 UART advanced by one request beat per bit-period tick.
// Channels:
//   req - opcode (bit tick, send byte, clear receive fill), rx_level, data_byte.
//   rsp - one beat per request: tx line level, tx_done, send_refused and the
//         receive outputs (rx_valid, rx_byte, rx_index, rx_stopped).
//   cfg - link_mode writes (idle, receive, transmit); always ready. The user
//         must write it only while no request is in flight (not enforced).
// Path: a request beat is captured in the input register, then processed into
// the response register, which shows it on rsp until it is taken.
// Throughput: one request beat per cycle unless rsp is held, set by the single
// processing register stage updating the UART state and the response register.
// Reset: all control state clears, the tx line sits at mark, both
// directions are disabled until link_mode is written.
// Stall: while rsp is held the response register keeps its beat, the input
// register holds one more request, and req.ready then drops.
module half_duplex_tick_uart (
    input  logic           clk,
    input  logic           rst_n,
    hdtu_cfg_if.sink       cfg,
    hdtu_req_if.sink       req,
    hdtu_rsp_if.source     rsp
);
    import hdtu_pkg::*;

    logic       in_valid_reg;
    req_item_t  in_data_reg;
    logic       out_valid_reg;
    rsp_item_t  out_data_reg;
    logic       advance;

    logic [3:0] bit_count_reg,   bit_count_next;
    logic [7:0] shift_data_reg,  shift_data_next;
    logic [7:0] rx_fill_reg,     rx_fill_next;
    logic       rx_active_reg,   rx_active_next;
    logic       tx_active_reg,   tx_active_next;
    logic       tx_finished_reg, tx_finished_next;
    logic       line_out_reg,    line_out_next;
    rsp_item_t  out_data_next;
    logic [3:0] cnt_step;

    assign advance   = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || advance;
    assign cfg.ready = 1'b1;
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

    always_comb
    begin
        bit_count_next   = bit_count_reg;
        shift_data_next  = shift_data_reg;
        rx_fill_next     = rx_fill_reg;
        rx_active_next   = rx_active_reg;
        tx_active_next   = tx_active_reg;
        tx_finished_next = tx_finished_reg;
        line_out_next    = line_out_reg;
        out_data_next    = '0;
        cnt_step         = '0;
        case (in_data_reg.opcode)
            OP_TICK:
            begin
                if (rx_active_reg)
                begin
                    if (bit_count_reg == 4'd0)
                    begin
                        if (!in_data_reg.rx_level)
                        begin
                            bit_count_next  = 4'd1;
                            shift_data_next = '0;
                        end
                    end
                    else
                    begin
                        cnt_step = bit_count_reg + 4'd1;
                        if (cnt_step <= CNT_DATA_END)
                        begin
                            bit_count_next  = cnt_step;
                            shift_data_next = {in_data_reg.rx_level, shift_data_reg[7:1]};
                            if (cnt_step == CNT_DATA_END)
                            begin
                                if (rx_fill_reg < 8'(RX_CAPACITY))
                                begin
                                    out_data_next.rx_valid = 1'b1;
                                    out_data_next.rx_byte  = shift_data_next;
                                    out_data_next.rx_index = rx_fill_reg[6:0];
                                    rx_fill_next           = rx_fill_reg + 8'd1;
                                end
                                else
                                begin
                                    rx_active_next           = 1'b0;
                                    out_data_next.rx_stopped = 1'b1;
                                end
                            end
                        end
                        else
                        begin
                            bit_count_next = '0;
                        end
                    end
                end
                else if (tx_active_reg)
                begin
                    if (bit_count_reg == 4'd0)
                    begin
                        cnt_step        = CNT_DATA_END;
                        shift_data_next = SHIFT_MARK;
                    end
                    else
                    begin
                        cnt_step = bit_count_reg - 4'd1;
                    end
                    bit_count_next = cnt_step;
                    if (cnt_step > 4'd1)
                    begin
                        line_out_next   = shift_data_next[0];
                        shift_data_next = {1'b0, shift_data_next[7:1]};
                    end
                    else
                    begin
                        line_out_next = 1'b1;
                        if (cnt_step == 4'd0)
                        begin
                            tx_finished_next = 1'b1;
                        end
                    end
                end
            end
            OP_SEND:
            begin
                if (tx_active_reg && tx_finished_reg)
                begin
                    shift_data_next  = in_data_reg.data_byte;
                    bit_count_next   = CNT_TX_LOAD;
                    line_out_next    = 1'b0;
                    tx_finished_next = 1'b0;
                end
                else
                begin
                    out_data_next.send_refused = 1'b1;
                end
            end
            OP_CLEAR:
            begin
                rx_fill_next = '0;
            end
            default:
            begin
            end
        endcase
        out_data_next.tx_level = line_out_next;
        out_data_next.tx_done  = tx_finished_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            bit_count_reg   <= '0;
            shift_data_reg  <= '0;
            rx_fill_reg     <= '0;
            rx_active_reg   <= 1'b0;
            tx_active_reg   <= 1'b0;
            tx_finished_reg <= 1'b0;
            line_out_reg    <= 1'b1;
        end
        else
        begin
            if (req.valid && req.ready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg   <= 1'b1;
                bit_count_reg   <= bit_count_next;
                shift_data_reg  <= shift_data_next;
                rx_fill_reg     <= rx_fill_next;
                rx_active_reg   <= rx_active_next;
                tx_active_reg   <= tx_active_next;
                tx_finished_reg <= tx_finished_next;
                line_out_reg    <= line_out_next;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg.valid)
            begin
                bit_count_reg <= '0;
                unique case (cfg.link_mode)
                    MODE_RX:
                    begin
                        rx_active_reg <= 1'b1;
                        tx_active_reg <= 1'b0;
                    end
                    MODE_TX:
                    begin
                        rx_active_reg   <= 1'b0;
                        tx_active_reg   <= 1'b1;
                        tx_finished_reg <= 1'b1;
                    end
                    default:
                    begin
                        rx_active_reg <= 1'b0;
                        tx_active_reg <= 1'b0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            in_data_reg <= req.data;
        end
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

    a_dir_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(rx_active_reg && tx_active_reg))
        else $error("receive and transmit enabled together");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        bit_count_reg <= CNT_TX_LOAD)
        else $error("bit count out of range");

    a_rx_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_data_reg.rx_valid && out_data_reg.rx_stopped))
        else $error("byte stored and receive halted on the same tick");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_valid_reg && !rsp.ready) |=> in_valid_reg)
        else $error("queued request lost during response stall");

endmodule

FILE: sim/tb_half_duplex_tick_uart.sv
`timescale 1ns / 100ps

module tb_half_duplex_tick_uart;
    import hdtu_pkg::*;

    localparam logic [1:0] MODE_SPARE  = 2'd3;
    localparam logic [1:0] OP_SPARE    = 2'd3;
    localparam int         HOLD_CYCLES = 300;
    localparam int         QUIET_LIMIT = 4000;

    logic clk;
    logic rst_n;

    hdtu_cfg_if cfg_ch ();
    hdtu_req_if req_ch ();
    hdtu_rsp_if rsp_ch ();

    half_duplex_tick_uart dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // UART state as seen from outside
    logic [7:0] m_count;
    logic [7:0] m_shift;
    logic [7:0] m_fill;
    logic       m_rx_on;
    logic       m_tx_on;
    logic       m_tx_fin;
    logic       m_line;

    rsp_item_t  due_beats[$];
    rsp_item_t  want;
    int         errors;
    int         n_beats;
    int         n_rx_bytes;
    int         n_frames;
    int         n_refused;
    int         n_stops;
    int         quiet;
    int         hold_ask;
    int         hold_seen;
    int         hold_left;
    logic       sink_gaps;
    bit         src_gaps;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void link_mode_write(input logic [1:0] mode);
        m_count = '0;
        case (mode)
            MODE_RX:
            begin
                m_rx_on = 1'b1;
                m_tx_on = 1'b0;
            end
            MODE_TX:
            begin
                m_tx_on  = 1'b1;
                m_rx_on  = 1'b0;
                m_tx_fin = 1'b1;
            end
            default:
            begin
                m_rx_on = 1'b0;
                m_tx_on = 1'b0;
            end
        endcase
    endfunction

    function automatic rsp_item_t uart_beat(input req_item_t it);
        rsp_item_t r;
        r = '0;
        case (it.opcode)
            OP_TICK:
            begin
                if (m_rx_on)
                begin
                    if (m_count == 0)
                    begin
                        if (!it.rx_level)
                        begin
                            m_count = 8'd1;
                            m_shift = '0;
                        end
                    end
                    else
                    begin
                        m_count = m_count + 8'd1;
                        if (m_count <= CNT_DATA_END)
                        begin
                            m_shift = {it.rx_level, m_shift[7:1]};
                            if (m_count == CNT_DATA_END)
                            begin
                                if (m_fill < RX_CAPACITY)
                                begin
                                    r.rx_valid = 1'b1;
                                    r.rx_byte  = m_shift;
                                    r.rx_index = m_fill[6:0];
                                    m_fill     = m_fill + 8'd1;
                                    n_rx_bytes++;
                                end
                                else
                                begin
                                    m_rx_on      = 1'b0;
                                    r.rx_stopped = 1'b1;
                                    n_stops++;
                                end
                            end
                        end
                        else
                            m_count = '0;
                    end
                end
                else if (m_tx_on)
                begin
                    m_count = m_count - 8'd1;
                    if (m_count > CNT_DATA_END)
                    begin
                        m_count = 8'(CNT_DATA_END);
                        m_shift = SHIFT_MARK;
                    end
                    if (m_count > 1)
                    begin
                        m_line  = m_shift[0];
                        m_shift = m_shift >> 1;
                    end
                    else
                    begin
                        m_line = 1'b1;
                        if (m_count == 0)
                            m_tx_fin = 1'b1;
                    end
                end
            end
            OP_SEND:
            begin
                if (m_tx_on && m_tx_fin)
                begin
                    m_shift  = it.data_byte;
                    m_count  = 8'(CNT_TX_LOAD);
                    m_line   = 1'b0;
                    m_tx_fin = 1'b0;
                    n_frames++;
                end
                else
                begin
                    r.send_refused = 1'b1;
                    n_refused++;
                end
            end
            OP_CLEAR:
                m_fill = '0;
            default:
                ;
        endcase
        r.tx_level = m_line;
        r.tx_done  = m_tx_fin;
        return r;
    endfunction

    task automatic check_field(input string what, input int unsigned exp_v,
                               input int unsigned act_v);
        if (exp_v != act_v)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, exp_v, act_v);
        end
    endtask

    // result side: check each beat, then decide ready for the next edge
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            hold_seen = hold_ask;
            hold_left = 0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (due_beats.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result beat, expected none, actual %p",
                             $time, rsp_ch.data);
                end
                else
                begin
                    want = due_beats.pop_front();
                    check_field("tx_level", 32'(want.tx_level),
                                32'(rsp_ch.data.tx_level));
                    check_field("tx_done", 32'(want.tx_done),
                                32'(rsp_ch.data.tx_done));
                    check_field("send_refused", 32'(want.send_refused),
                                32'(rsp_ch.data.send_refused));
                    check_field("rx_valid", 32'(want.rx_valid),
                                32'(rsp_ch.data.rx_valid));
                    check_field("rx_byte", 32'(want.rx_byte),
                                32'(rsp_ch.data.rx_byte));
                    check_field("rx_index", 32'(want.rx_index),
                                32'(rsp_ch.data.rx_index));
                    check_field("rx_stopped", 32'(want.rx_stopped),
                                32'(rsp_ch.data.rx_stopped));
                end
            end
            if (hold_ask != hold_seen)
            begin
                hold_seen = hold_ask;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= !sink_gaps || ($urandom_range(99) >= 22);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            quiet <= 0;
        else if (quiet >= QUIET_LIMIT)
        begin
            $display("%0t: no beat moved for %0d cycles", $time, quiet);
            $display("** half_duplex_tick_uart: FAILED **");
            $finish;
        end
        else
            quiet <= quiet + 1;
    end

    task automatic send_item(input logic [1:0] op, input logic lvl, input logic [7:0] b);
        req_item_t it;
        it.opcode    = op;
        it.rx_level  = lvl;
        it.data_byte = b;
        if (src_gaps && $urandom_range(99) < 22)
        begin
            req_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < 22);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= it;
        do
            @(posedge clk);
        while (!req_ch.ready);
        n_beats++;
        due_beats.push_back(uart_beat(it));
    endtask

    task automatic drain_results();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (due_beats.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_link_mode(input logic [1:0] mode);
        drain_results();
        cfg_ch.valid     <= 1'b1;
        cfg_ch.link_mode <= mode;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        link_mode_write(mode);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic send_tx_frame(input logic [7:0] b, input int ticks);
        send_item(OP_SEND, 1'($urandom_range(1)), b);
        repeat (ticks)
            send_item(OP_TICK, 1'($urandom_range(1)), 8'($urandom_range(255)));
    endtask

    task automatic send_rx_frame(input logic [7:0] b);
        send_item(OP_TICK, 1'b0, 8'($urandom_range(255)));
        for (int i = 0; i < 8; i++)
            send_item(OP_TICK, b[i], 8'($urandom_range(255)));
        send_item(OP_TICK, 1'b1, 8'($urandom_range(255)));
    endtask

    task automatic test_directed();
        send_item(OP_TICK, 1'b0, 8'h00);
        send_item(OP_SEND, 1'b1, 8'hFF);
        send_item(OP_SPARE, 1'b1, 8'hFF);
        send_item(OP_CLEAR, 1'b0, 8'h00);
        write_link_mode(MODE_TX);
        send_item(OP_SEND, 1'b0, 8'hA5);
        send_item(OP_SEND, 1'b1, 8'h5A);
        repeat (10) send_item(OP_TICK, 1'b0, 8'h00);
        // idle transmitter wraps through mark frames
        send_item(OP_TICK, 1'b1, 8'hFF);
        write_link_mode(MODE_SPARE);
        send_item(OP_TICK, 1'b0, 8'h00);
        send_item(OP_SEND, 1'b0, 8'h3C);
        write_link_mode(MODE_RX);
        send_item(OP_SEND, 1'b1, 8'hC3);
    endtask

    task automatic test_transmit();
        int pick;
        write_link_mode(MODE_TX);
        send_tx_frame(8'h00, 10);
        send_tx_frame(8'hFF, 11);
        for (int i = 0; i < 16; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 65)
                send_tx_frame(8'($urandom_range(255)), 10 + $urandom_range(2));
            else if (pick < 85)
                send_tx_frame(8'($urandom_range(255)), $urandom_range(1, 9));
            else
                repeat ($urandom_range(1, 4))
                    send_item(2'($urandom_range(3)), 1'($urandom_range(1)),
                              8'($urandom_range(255)));
        end
        write_link_mode(MODE_IDLE);
        repeat (6)
            send_item(2'($urandom_range(3)), 1'($urandom_range(1)), 8'($urandom_range(255)));
        write_link_mode(MODE_TX);
        send_tx_frame(8'($urandom_range(255)), 4);
        write_link_mode(MODE_TX);
        send_tx_frame(8'($urandom_range(255)), 10);
    endtask

    task automatic test_backpressure();
        write_link_mode(MODE_TX);
        hold_ask <= hold_ask + 1;
        repeat (4) send_tx_frame(8'($urandom_range(255)), 10);
        drain_results();
        repeat (2) send_tx_frame(8'($urandom_range(255)), 10);
    endtask

    task automatic test_receive();
        int pick;
        write_link_mode(MODE_RX);
        src_gaps = 1'b0;
        sink_gaps <= 1'b0;
        for (int i = 0; i < 18; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
                send_rx_frame(8'($urandom_range(255)));
            else if (pick < 80)
            begin
                send_item(OP_TICK, 1'b0, 8'($urandom_range(255)));
                repeat ($urandom_range(1, 8))
                    send_item(OP_TICK, 1'($urandom_range(1)), 8'($urandom_range(255)));
            end
            else if (pick < 90)
                repeat ($urandom_range(1, 3))
                    send_item(OP_TICK, 1'b1, 8'($urandom_range(255)));
            else
                send_item(2'($urandom_range(1, 3)), 1'($urandom_range(1)),
                          8'($urandom_range(255)));
        end
        src_gaps = 1'b1;
        sink_gaps <= 1'b1;
        send_rx_frame(8'h00);
        send_rx_frame(8'hFF);
        // abandon a frame half way through with a mode change
        send_item(OP_TICK, 1'b0, 8'($urandom_range(255)));
        repeat (4) send_item(OP_TICK, 1'($urandom_range(1)), 8'($urandom_range(255)));
        write_link_mode(MODE_TX);
        send_item(OP_TICK, 1'($urandom_range(1)), 8'($urandom_range(255)));
        write_link_mode(MODE_RX);
        repeat (2) send_rx_frame(8'($urandom_range(255)));
    endtask

    task automatic test_buffer_full();
        int guard;
        guard = 0;
        while (m_rx_on && guard < 300)
        begin
            send_rx_frame(8'($urandom_range(255)));
            if ($urandom_range(9) == 0)
                send_item(OP_TICK, 1'b1, 8'($urandom_range(255)));
            guard++;
        end
        repeat (3) send_item(OP_TICK, 1'($urandom_range(1)), 8'($urandom_range(255)));
        send_rx_frame(8'($urandom_range(255)));
        send_item(OP_CLEAR, 1'($urandom_range(1)), 8'($urandom_range(255)));
        write_link_mode(MODE_RX);
        repeat (3) send_rx_frame(8'($urandom_range(255)));
        write_link_mode(MODE_IDLE);
        repeat (3)
            send_item(2'($urandom_range(3)), 1'($urandom_range(1)), 8'($urandom_range(255)));
    endtask

    initial
    begin
        rst_n            <= 1'b0;
        req_ch.valid     <= 1'b0;
        req_ch.data      <= '0;
        cfg_ch.valid     <= 1'b0;
        cfg_ch.link_mode <= MODE_IDLE;
        sink_gaps        <= 1'b1;
        hold_ask         <= 0;
        src_gaps   = 1'b1;
        n_beats    = 0;
        n_rx_bytes = 0;
        n_frames   = 0;
        n_refused  = 0;
        n_stops    = 0;
        m_count    = '0;
        m_shift    = '0;
        m_fill     = '0;
        m_rx_on    = 1'b0;
        m_tx_on    = 1'b0;
        m_tx_fin   = 1'b0;
        m_line     = 1'b1;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_transmit();
        test_backpressure();
        test_receive();
        test_buffer_full();

        drain_results();
        repeat (6) @(posedge clk);
        $display("Run covered %0d request beats in idle, receive, transmit and spare modes,",
                 n_beats);
        $display("with %0d bytes received, %0d frames sent, %0d sends refused, %0d full stops.",
                 n_rx_bytes, n_frames, n_refused, n_stops);
        if (errors == 0 && due_beats.size() == 0)
            $display("** half_duplex_tick_uart: PASSED **");
        else
            $display("** half_duplex_tick_uart: FAILED **");
        $finish;
    end

endmodule
